/* src/olid_pkg.sv */
// Shared types and constants for the ordered list insert/delete block.
// No dependencies; imported by ordered_list_insert_delete.
`default_nettype none

package olid_pkg;

    // Width of the entry_total result field.
    localparam int TOTAL_W = 6;
    // Width of one stored value.
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_DUMP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_DUMP  = 2'd3
    } t_state;

endpackage

`default_nettype wire

/* src/ordered_list_insert_delete.sv */
// Ordered list of up to CAPACITY signed 32-bit values kept as a circular buffer
// in a small RAM. Each request carries one command: insert at the front, insert
// at the back, delete the first entry equal to a value, or dump the list from
// front to back. Inserts, deletes and an empty dump answer with one result; a
// dump of N entries answers with N results, the final one flagged by
// o_last_of_run. Timing is set by the single RAM read port that a small
// sequencer walks one entry per cycle while the output side is not stalled:
// inserts and an empty dump are answered from the idle state, a dump starts
// the first read and then gives one result per entry, and a delete does a search up
// to the match, then a compaction pass that moves each later entry down one
// place. The block takes no new request until the current one has put its
// last result into the output register and that register is empty or being
// read out, so the next request can be taken in the same cycle that the final
// result is accepted downstream. A stall on the output side freezes the
// sequencer in place. The store needs no clearing after reset: only entries
// that have been written are ever read.
// Depends on olid_pkg and olid_ram.
`default_nettype none

module ordered_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Request channel.
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_command,
    input  wire logic signed [olid_pkg::VALUE_W-1:0] i_item_value,
    // Result channel.
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [olid_pkg::VALUE_W-1:0]   o_out_value,
    output logic [1:0]                            o_status,
    output logic                                  o_last_of_run,
    output logic [olid_pkg::TOTAL_W-1:0]          o_entry_total
);

    import olid_pkg::*;

    // Slot address width and entry count width (count must hold CAPACITY).
    localparam int FW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = ((FW > CW) ? FW : CW) + 1;

    // Sequencer and list state.
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [FW-1:0]        r_front, n_front;
    logic [CW-1:0]        r_idx,   n_idx;     // next logical index to read
    logic [CW-1:0]        r_pos,   n_pos;     // logical index of the read data
    logic                 r_rd_vld, n_rd_vld; // RAM read data is meaningful
    logic [VALUE_W-1:0]   r_val,   n_val;     // value searched for by a delete

    // Output register.
    logic                 r_o_valid, n_o_valid;
    logic [VALUE_W-1:0]   r_o_value, n_o_value;
    t_status              r_o_status, n_o_status;
    logic                 r_o_last, n_o_last;
    logic [TOTAL_W-1:0]   r_o_total, n_o_total;

    // RAM port signals.
    logic                 w_wr_en;
    logic [FW-1:0]        w_wr_addr;
    logic [VALUE_W-1:0]   w_wr_data;
    logic                 w_rd_en;
    logic [FW-1:0]        w_rd_addr;
    logic [VALUE_W-1:0]   w_rd_data;

    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_more;
    logic                 w_hit;
    logic                 w_last_pos;
    logic [FW-1:0]        w_front_dec;
    logic [CW-1:0]        w_wr_logical;
    t_cmd                 w_cmd;

    // Physical slot of a logical position: front plus offset, wrapped once.
    function automatic logic [FW-1:0] slot_of(input logic [FW-1:0] front,
                                              input logic [CW-1:0] logical);
        logic [SW-1:0] sum;
        sum = SW'(front) + SW'(logical);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[FW-1:0];
    endfunction

    assign w_cmd      = t_cmd'(i_command);
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_more     = (r_idx < r_count);
    assign w_hit      = r_rd_vld && (w_rd_data == r_val);
    assign w_last_pos = (r_pos == r_count - CW'(1));
    assign w_front_dec = (r_front == '0) ? FW'(CAPACITY - 1) : r_front - FW'(1);

    assign w_rd_addr = slot_of(r_front, r_idx);

    olid_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (FW),
        .DATA_W (VALUE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == CMD_DELETE) begin
                        n_state = S_SCAN;
                    end else if (w_cmd == CMD_DUMP && r_count != '0) begin
                        n_state = S_DUMP;
                    end
                end
            end
            S_SCAN: begin
                if (w_out_free) begin
                    if (w_hit) begin
                        n_state = S_SHIFT;
                    end else if (!w_more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHIFT: begin
                if (w_out_free && !w_more) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (w_out_free && r_rd_vld && w_last_pos) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM control and result generation.
    always_comb begin
        n_count      = r_count;
        n_front      = r_front;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_rd_vld     = r_rd_vld;
        n_val        = r_val;
        n_o_valid    = r_o_valid && i_out_stall;
        n_o_value    = r_o_value;
        n_o_status   = r_o_status;
        n_o_last     = r_o_last;
        n_o_total    = r_o_total;
        w_wr_en      = 1'b0;
        w_wr_data    = i_item_value;
        w_wr_logical = r_count;
        w_rd_en      = 1'b0;
        w_wr_addr    = slot_of(r_front, w_wr_logical);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_val    = i_item_value;
                    case (w_cmd)
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            n_o_valid  = 1'b1;
                            n_o_value  = '0;
                            n_o_last   = 1'b1;
                            if (w_full) begin
                                n_o_status = ST_FULL;
                            end else begin
                                w_wr_en    = 1'b1;
                                n_count    = r_count + CW'(1);
                                n_o_status = ST_DONE;
                                if (w_cmd == CMD_INS_FRONT) begin
                                    n_front   = w_front_dec;
                                    w_wr_addr = w_front_dec;
                                end
                            end
                            n_o_total = TOTAL_W'(n_count);
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_o_valid  = 1'b1;
                                n_o_value  = '0;
                                n_o_status = ST_EMPTY;
                                n_o_last   = 1'b1;
                                n_o_total  = TOTAL_W'(r_count);
                            end
                        end
                        default: begin
                            // Delete starts its search in the next cycle.
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_out_free) begin
                    if (w_hit) begin
                        n_idx    = r_pos + CW'(1);
                        n_rd_vld = 1'b0;
                    end else if (w_more) begin
                        w_rd_en  = 1'b1;
                        n_pos    = r_idx;
                        n_idx    = r_idx + CW'(1);
                        n_rd_vld = 1'b1;
                    end else begin
                        n_rd_vld   = 1'b0;
                        n_o_valid  = 1'b1;
                        n_o_value  = '0;
                        n_o_status = ST_NOT_FOUND;
                        n_o_last   = 1'b1;
                        n_o_total  = TOTAL_W'(r_count);
                    end
                end
            end
            S_SHIFT: begin
                if (w_out_free) begin
                    // Move the entry just read down one logical place.
                    w_wr_logical = r_pos - CW'(1);
                    w_wr_addr    = slot_of(r_front, w_wr_logical);
                    w_wr_data    = w_rd_data;
                    w_wr_en      = r_rd_vld;
                    if (w_more) begin
                        w_rd_en  = 1'b1;
                        n_pos    = r_idx;
                        n_idx    = r_idx + CW'(1);
                        n_rd_vld = 1'b1;
                    end else begin
                        n_rd_vld   = 1'b0;
                        n_count    = r_count - CW'(1);
                        n_o_valid  = 1'b1;
                        n_o_value  = '0;
                        n_o_status = ST_DONE;
                        n_o_last   = 1'b1;
                        n_o_total  = TOTAL_W'(n_count);
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    if (r_rd_vld) begin
                        n_o_valid  = 1'b1;
                        n_o_value  = w_rd_data;
                        n_o_status = ST_DONE;
                        n_o_last   = w_last_pos;
                        n_o_total  = TOTAL_W'(r_count);
                    end
                    if (w_more) begin
                        w_rd_en  = 1'b1;
                        n_pos    = r_idx;
                        n_idx    = r_idx + CW'(1);
                        n_rd_vld = 1'b1;
                    end else begin
                        n_rd_vld = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_front   <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_front   <= n_front;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
        r_o_total  <= n_o_total;
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_value   = $signed(r_o_value);
    assign o_status      = r_o_status;
    assign o_last_of_run = r_o_last;
    assign o_entry_total = r_o_total;

    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The front slot always addresses a real entry of the store.
    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_front} < (FW+1)'(CAPACITY))
        else $error("front slot out of range");

    // A walk never reads past the last held entry.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx <= r_count))
        else $error("read index beyond entry count");

    // Finishing a compaction pass removes exactly one entry.
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && w_out_free && !w_more)
            |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not remove one entry");

endmodule

`default_nettype wire

/* src/olid_ram.sv */
// Single-port-write, single-port-read value store with a registered read.
// Depends on nothing; used by ordered_list_insert_delete.
`default_nettype none

module olid_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
